>>> rtl/core/dss_pkg.sv
// Shared types and constants for the dual stack core.
// No dependencies; imported by dss_ctrl, dss_datapath and the top level.
`timescale 1ns / 1ps

package dss_pkg;

  // Default number of 32-bit words in the shared memory
  localparam int unsigned DSS_DEPTH = 128;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_ONE = 3'd0,
    CMD_PUSH_TWO = 3'd1,
    CMD_POP_ONE  = 3'd2,
    CMD_POP_TWO  = 3'd3,
    CMD_PEEK_ONE = 3'd4,
    CMD_PEEK_TWO = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // execute the item on the slave port this cycle
    logic load_out;  // move the step result into the output register
  } dss_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_valid; // output register holds a result not yet taken
  } dss_sts_t;

endpackage

>>> rtl/core/dss_ctrl.sv
// Controller for the dual stack core: sequences accept and result load.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic              m_axis_tready_i,
  input  dss_pkg::dss_sts_t sts_i,
  output dss_pkg::dss_cmd_t cmd_o
);
  import dss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOAD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_free;
  logic   accept;

  // Output slot is free if empty or being drained this cycle
  assign out_free        = !sts_i.out_valid || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Read data is registered now; hand the result over
        cmd_o.load_out = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Every accepted item is loaded into the output on the next cycle
  a_accept_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> cmd_o.load_out)
    else $error("accepted item not followed by result load");

  // No new item while a result is being loaded
  a_no_accept_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !s_axis_tready_o)
    else $error("input ready during result load");

endmodule

>>> rtl/core/dss_datapath.sv
// Datapath for the dual stack core: stack counters, shared memory,
// result staging and the output register. Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_datapath #(
  parameter int unsigned DEPTH = dss_pkg::DSS_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dss_pkg::dss_cmd_t                 cmd_i,
  output dss_pkg::dss_sts_t                 sts_o,
  input  logic [dss_pkg::CMD_W-1:0]         command_i,
  input  logic signed [dss_pkg::DATA_W-1:0] data_in_i,
  input  logic                              m_axis_tready_i,
  output logic                              m_axis_tvalid_o,
  output logic signed [dss_pkg::DATA_W-1:0] data_out_o,
  output logic [dss_pkg::STAT_W-1:0]        status_o,
  output logic                              empty_one_o,
  output logic                              empty_two_o
);
  import dss_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW-1:0] TOP_C     = CW'(DEPTH - 1);

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  logic [CW-1:0] cnt_lo_q, cnt_lo_d;
  logic [CW-1:0] cnt_hi_q, cnt_hi_d;
  logic [CW:0]   cnt_sum;
  logic          full;

  logic          mem_we, mem_re;
  logic [CW-1:0] addr_w;
  logic [AW-1:0] addr;

  status_e       stat_d, stat_q;
  logic          rd_sel_q;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_data_q;
  logic [STAT_W-1:0]        out_stat_q;
  logic                     out_e1_q, out_e2_q;

  assign cnt_sum = {1'b0, cnt_lo_q} + {1'b0, cnt_hi_q};
  assign full    = (cnt_sum >= DEPTH_SUM);
  assign addr    = addr_w[AW-1:0];

  // Command decode: pointer update and memory access
  always_comb begin
    cnt_lo_d = cnt_lo_q;
    cnt_hi_d = cnt_hi_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    addr_w   = cnt_lo_q;
    stat_d   = STAT_OK;
    case (cmd_e'(command_i))
      CMD_PUSH_ONE: begin
        if (full) begin
          stat_d = STAT_OVERFLOW;
        end else begin
          mem_we   = cmd_i.accept;
          addr_w   = cnt_lo_q;
          cnt_lo_d = cnt_lo_q + 1'b1;
        end
      end
      CMD_PUSH_TWO: begin
        if (full) begin
          stat_d = STAT_OVERFLOW;
        end else begin
          mem_we   = cmd_i.accept;
          addr_w   = TOP_C - cnt_hi_q;
          cnt_hi_d = cnt_hi_q + 1'b1;
        end
      end
      CMD_POP_ONE, CMD_PEEK_ONE: begin
        if (cnt_lo_q == '0) begin
          stat_d = STAT_UNDERFLOW;
        end else begin
          mem_re = cmd_i.accept;
          addr_w = cnt_lo_q - 1'b1;
          if (cmd_e'(command_i) == CMD_POP_ONE) begin
            cnt_lo_d = cnt_lo_q - 1'b1;
          end
        end
      end
      CMD_POP_TWO, CMD_PEEK_TWO: begin
        if (cnt_hi_q == '0) begin
          stat_d = STAT_UNDERFLOW;
        end else begin
          mem_re = cmd_i.accept;
          addr_w = DEPTH_C - cnt_hi_q;
          if (cmd_e'(command_i) == CMD_POP_TWO) begin
            cnt_hi_d = cnt_hi_q - 1'b1;
          end
        end
      end
      default: begin
        stat_d = STAT_OK;
      end
    endcase
  end

  // Stack counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_lo_q <= '0;
      cnt_hi_q <= '0;
    end else if (cmd_i.accept) begin
      cnt_lo_q <= cnt_lo_d;
      cnt_hi_q <= cnt_hi_d;
    end
  end

  // Shared single-port memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr] <= data_in_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Per-item status held until the result is loaded
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      stat_q   <= stat_d;
      rd_sel_q <= mem_re;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= rd_sel_q ? rdata_q : '0;
      out_stat_q <= stat_q;
      out_e1_q   <= (cnt_lo_q == '0);
      out_e2_q   <= (cnt_hi_q == '0);
    end
  end

  assign sts_o.out_valid = out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign data_out_o      = out_data_q;
  assign status_o        = out_stat_q;
  assign empty_one_o     = out_e1_q;
  assign empty_two_o     = out_e2_q;

  // The two stacks never hold more than the memory
  a_no_overcommit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_sum <= DEPTH_SUM)
    else $error("stack counts exceed memory depth");

  // A result is only loaded into an empty output register
  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !out_valid_q)
    else $error("output register overwritten");

  // A successful push onto stack one grows it by exactly one
  a_push_one_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && (cmd_e'(command_i) == CMD_PUSH_ONE) && !full)
      |=> (cnt_lo_q == $past(cnt_lo_q) + 1'b1) && $stable(cnt_hi_q))
    else $error("push onto stack one miscounted");

endmodule

>>> rtl/core/dual_stack_shared_memory_core.sv
// Top level of the dual stack core: two stacks sharing one memory.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
`timescale 1ns / 1ps

// Two stacks live in one memory of DEPTH 32-bit words: stack one grows up
// from word 0, stack two grows down from word DEPTH-1. Each input item is a
// command (push, pop or peek on either stack) and yields exactly one result
// item with the popped or peeked value, a status (ok, overflow on a push
// into a full memory, underflow on a pop or peek of an empty stack) and both
// empty flags after the step. Errors and unused commands change no state.
// An item first updates the stack pointers and accesses the single-port
// memory, then the registered read data reaches the output register. A new
// item is taken only after the last one reached the output register, and
// only while that register is empty or drained in that cycle; a stalled
// master port holds the slave port. The memory is not cleared after reset;
// a pop or peek only ever reads a word that a push wrote.
module dual_stack_shared_memory_core #(
  parameter int unsigned DEPTH = dss_pkg::DSS_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Slave side
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic signed [dss_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] data_in
  input  logic [dss_pkg::CMD_W-1:0]         s_axis_tuser_i,  // [2:0] command
  // Master side
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic signed [dss_pkg::DATA_W-1:0] m_axis_tdata_o,  // [31:0] data_out
  output logic [3:0]                        m_axis_tuser_o   // [1:0] status,
                                                             // [2] empty_one,
                                                             // [3] empty_two
);
  import dss_pkg::*;

  dss_cmd_t          cmd;
  dss_sts_t          sts;
  logic [STAT_W-1:0] status;
  logic              empty_one;
  logic              empty_two;

  // Sequencer
  dss_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tready_i (m_axis_tready_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // Counters, memory and output register
  dss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (s_axis_tuser_i),
    .data_in_i       (s_axis_tdata_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .data_out_o      (m_axis_tdata_o),
    .status_o        (status),
    .empty_one_o     (empty_one),
    .empty_two_o     (empty_two)
  );

  assign m_axis_tuser_o = {empty_two, empty_one, status};

endmodule

>>> sim/dss_checker.sv
// Scoreboard for the dual stack core: watches both stream ports, predicts each result.
// Depends on dss_pkg; instantiated by tb_dual_stack_shared_memory_core.
`timescale 1ns / 1ps

module dss_checker #(
  parameter int unsigned DEPTH = dss_pkg::DSS_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_i,
  input  logic [dss_pkg::DATA_W-1:0]  s_axis_tdata_i,   // [31:0] data_in
  input  logic [dss_pkg::CMD_W-1:0]   s_axis_tuser_i,   // [2:0] command
  input  logic                        m_axis_tvalid_i,
  input  logic                        m_axis_tready_i,
  input  logic [dss_pkg::DATA_W-1:0]  m_axis_tdata_i,   // [31:0] data_out
  input  logic [3:0]                  m_axis_tuser_i,   // [1:0] status, [2] empty_one,
                                                        // [3] empty_two
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_o
);
  import dss_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_e           status;
    logic              empty_one;
    logic              empty_two;
  } stack_result_t;

  // Shadow copy of the shared memory and both stack depths
  logic [DATA_W-1:0] shadow_mem [DEPTH];
  int unsigned       depth_one;
  int unsigned       depth_two;
  stack_result_t     expected_q [$];
  int unsigned       result_idx;

  // Execute one command on the shadow stacks and return its result
  function automatic stack_result_t apply_command(logic [CMD_W-1:0] code,
                                                  logic [DATA_W-1:0] value);
    stack_result_t res;
    logic          is_full;
    res.value  = '0;
    res.status = STAT_OK;
    is_full    = (depth_one + depth_two >= DEPTH);
    case (code)
      CMD_PUSH_ONE: begin
        if (is_full) res.status = STAT_OVERFLOW;
        else begin
          shadow_mem[depth_one] = value;
          depth_one++;
        end
      end
      CMD_PUSH_TWO: begin
        if (is_full) res.status = STAT_OVERFLOW;
        else begin
          depth_two++;
          shadow_mem[DEPTH - depth_two] = value;
        end
      end
      CMD_POP_ONE, CMD_PEEK_ONE: begin
        if (depth_one == 0) res.status = STAT_UNDERFLOW;
        else begin
          res.value = shadow_mem[depth_one - 1];
          if (code == CMD_POP_ONE) depth_one--;
        end
      end
      CMD_POP_TWO, CMD_PEEK_TWO: begin
        if (depth_two == 0) res.status = STAT_UNDERFLOW;
        else begin
          res.value = shadow_mem[DEPTH - depth_two];
          if (code == CMD_POP_TWO) depth_two--;
        end
      end
      default: ;  // unused codes leave the stacks alone
    endcase
    res.empty_one = (depth_one == 0);
    res.empty_two = (depth_two == 0);
    return res;
  endfunction

  // Compare results first, then queue the prediction for a newly taken item
  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t got;
    stack_result_t want;
    if (!rst_ni) begin
      depth_one  = 0;
      depth_two  = 0;
      result_idx = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.value     = m_axis_tdata_i;
        got.status    = status_e'(m_axis_tuser_i[1:0]);
        got.empty_one = m_axis_tuser_i[2];
        got.empty_two = m_axis_tuser_i[3];
        if (expected_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result %0d arrived with no command pending: data %h status %0d",
                     $realtime, result_idx, got.value, got.status);
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.status !== want.status ||
              got.empty_one !== want.empty_one || got.empty_two !== want.empty_two) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display({"%0t: result %0d expected data %h status %0d empty %b/%b, ",
                        "got data %h status %0d empty %b/%b"},
                       $realtime, result_idx, want.value, want.status, want.empty_one,
                       want.empty_two, got.value, got.status, got.empty_one, got.empty_two);
          end
        end
        result_idx++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_q.push_back(apply_command(s_axis_tuser_i, s_axis_tdata_i));
    end
    pending_o = expected_q.size();
  end

endmodule

>>> sim/tb_dual_stack_shared_memory_core.sv
// Testbench top for the dual stack core: clock, reset, command stimulus and verdict.
// Depends on dss_pkg, dual_stack_shared_memory_core and dss_checker.
`timescale 1ns / 1ps

module tb_dual_stack_shared_memory_core;
  import dss_pkg::*;

  localparam int unsigned DEPTH       = DSS_DEPTH;
  localparam int unsigned ITEM_TARGET = 830;
  // Codes with no operation behind them
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  typedef enum int {SEG_MIX, SEG_FILL, SEG_DRAIN} segment_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]  s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [3:0]        m_tuser;
  int unsigned       mismatch_count;
  int unsigned       pending;

  // Stimulus-side view of the stack depths, used only to shape sequences
  int unsigned       occ_one = 0;
  int unsigned       occ_two = 0;
  int unsigned       items_sent = 0;
  bit                no_stall = 1'b0;

  dual_stack_shared_memory_core #(.DEPTH(DEPTH)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  dss_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tuser_i   (s_tuser),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .m_axis_tuser_i   (m_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Value mix: mostly random, some extremes
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one item after a random gap and wait until it is taken
  task automatic send_command(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] value);
    int unsigned gap;
    gap = no_stall ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= code;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    case (code)
      CMD_PUSH_ONE: if (occ_one + occ_two < DEPTH) occ_one++;
      CMD_PUSH_TWO: if (occ_one + occ_two < DEPTH) occ_two++;
      CMD_POP_ONE:  if (occ_one != 0) occ_one--;
      CMD_POP_TWO:  if (occ_two != 0) occ_two--;
      default: ;
    endcase
    items_sent++;
  endtask

  // Hold the sender until every result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Random command with a push bias
  task automatic send_mixed();
    int unsigned      r;
    logic [CMD_W-1:0] code;
    r = $urandom_range(0, 19);
    if (r < 4)       code = CMD_PUSH_ONE;
    else if (r < 8)  code = CMD_PUSH_TWO;
    else if (r < 11) code = CMD_POP_ONE;
    else if (r < 14) code = CMD_POP_TWO;
    else if (r < 16) code = CMD_PEEK_ONE;
    else if (r < 18) code = CMD_PEEK_TWO;
    else if (r == 18) code = CMD_UNUSED_A;
    else             code = CMD_UNUSED_B;
    send_command(code, pick_value());
  endtask

  task automatic send_peek();
    send_command($urandom_range(0, 1) ? CMD_PEEK_TWO : CMD_PEEK_ONE, pick_value());
  endtask

  task automatic run_segment(input segment_e kind);
    no_stall = ($urandom_range(0, 3) == 0);
    case (kind)
      // Fill the memory from both ends, then push into a full memory
      SEG_FILL: begin
        while (occ_one + occ_two < DEPTH) begin
          if ($urandom_range(0, 9) == 0) send_peek();
          else send_command($urandom_range(0, 1) ? CMD_PUSH_TWO : CMD_PUSH_ONE, pick_value());
        end
        repeat ($urandom_range(1, 4))
          send_command($urandom_range(0, 1) ? CMD_PUSH_TWO : CMD_PUSH_ONE, pick_value());
      end
      // Empty both stacks, then pop and peek on empty stacks
      SEG_DRAIN: begin
        while (occ_one + occ_two > 0) begin
          if ($urandom_range(0, 9) == 0) send_peek();
          else if (occ_one == 0) send_command(CMD_POP_TWO, pick_value());
          else if (occ_two == 0) send_command(CMD_POP_ONE, pick_value());
          else send_command($urandom_range(0, 1) ? CMD_POP_TWO : CMD_POP_ONE, pick_value());
        end
        repeat ($urandom_range(1, 3))
          send_command($urandom_range(0, 1) ? CMD_POP_TWO : CMD_POP_ONE, pick_value());
        send_peek();
      end
      default: begin
        repeat ($urandom_range(20, 60)) send_mixed();
      end
    endcase
  endtask

  // Result side: random stalls, with stall-free stretches
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  // Reset, directed commands, random segments, verdict
  initial begin
    int unsigned seg_idx;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty stacks, unused codes, extreme values, LIFO order on both stacks
    send_command(CMD_PEEK_ONE, 32'h0000_0001);
    send_command(CMD_PEEK_TWO, 32'hffff_ffff);
    send_command(CMD_POP_ONE, 32'h8000_0000);
    send_command(CMD_POP_TWO, 32'h7fff_ffff);
    send_command(CMD_UNUSED_A, 32'h1234_5678);
    send_command(CMD_UNUSED_B, 32'hffff_ffff);
    send_command(CMD_PUSH_ONE, 32'h7fff_ffff);
    send_command(CMD_PUSH_ONE, 32'h8000_0000);
    send_command(CMD_PUSH_TWO, 32'h0000_0000);
    send_command(CMD_PUSH_TWO, 32'hffff_ffff);
    send_command(CMD_PUSH_ONE, 32'h5555_5555);
    send_command(CMD_PUSH_TWO, 32'haaaa_aaaa);
    send_command(CMD_UNUSED_B, 32'h0000_0000);
    send_command(CMD_PEEK_ONE, 32'h0);
    send_command(CMD_PEEK_TWO, 32'h0);
    send_command(CMD_POP_ONE, 32'h0);
    send_command(CMD_POP_ONE, 32'h0);
    send_command(CMD_POP_ONE, 32'h0);
    send_command(CMD_POP_ONE, 32'h0);
    send_command(CMD_POP_TWO, 32'h0);
    send_command(CMD_POP_TWO, 32'h0);
    send_command(CMD_PEEK_TWO, 32'h0);
    send_command(CMD_POP_TWO, 32'h0);
    send_command(CMD_POP_TWO, 32'h0);
    wait_drained();

    // Random part: fill and drain first, then any mix
    seg_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (seg_idx == 0) run_segment(SEG_FILL);
      else if (seg_idx == 1) run_segment(SEG_DRAIN);
      else run_segment(segment_e'($urandom_range(0, 2)));
      seg_idx++;
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
